>>> rtl/core/n_queens_backtrack_solver_top_macros.svh
// Assertion macros used by the n-queens solver datapath.
// Define ASSERT_OFF to compile the checks out.
`ifndef N_QUEENS_BACKTRACK_SOLVER_TOP_MACROS_SVH
`define N_QUEENS_BACKTRACK_SOLVER_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// Implication check, sampled on the rising clock, off during reset
`define NQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Invariant check, sampled on the rising clock, off during reset
`define NQ_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

`else

`define NQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define NQ_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)

`endif

`endif

>>> rtl/core/nqbs_pkg.sv
// Shared types and constants for the n-queens backtracking solver.
// No dependencies; imported by the controller, the datapath and the top.
`timescale 1ns / 1ps

package nqbs_pkg;

    // Fixed field widths of the stream payload
    localparam int IN_W      = 5;
    localparam int COL_W     = 4;
    localparam int ROW_W     = 4;
    // Largest board the output fields can report
    localparam int BOARD_CAP = 16;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;       // capture board size, clear masks and counters
        logic place;      // store queen, set masks, next column
        logic advance;    // try next row
        logic dec_col;    // step back one column, read its stored row
        logic pop;        // remove stored queen, resume at row + 1
        logic out_start;  // rewind column counter for readout
        logic emit_row;   // load one found result into output register
        logic next_col;   // readout: next column
        logic emit_none;  // load not-found result into output register
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic n_zero;     // board size is zero
        logic col_done;   // all columns filled
        logic row_done;   // rows of this column exhausted
        logic col_zero;   // at first column
        logic safe;       // trial cell is not attacked
        logic last_col;   // column is the last one of the board
        logic out_free;   // output register can take a result
    } status_t;

endpackage

>>> rtl/core/nqbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module nqbs_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/nqbs_datapath.sv
// Datapath of the n-queens solver: counters, occupancy masks, row store,
// safety check and output register. Depends on nqbs_pkg, nqbs_ram, macros.
`timescale 1ns / 1ps
`include "n_queens_backtrack_solver_top_macros.svh"

module nqbs_datapath #(
    parameter int MAX_BOARD = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  nqbs_pkg::cmd_t                cmd,
    output nqbs_pkg::status_t             st,
    input  logic [nqbs_pkg::IN_W-1:0]     board_size,
    output logic [nqbs_pkg::COL_W-1:0]    out_col,
    output logic [nqbs_pkg::ROW_W-1:0]    out_row,
    output logic                          out_found,
    output logic                          out_last,
    output logic                          out_valid,
    input  logic                          out_ready
);

    import nqbs_pkg::*;

    localparam int LIMIT = (MAX_BOARD < BOARD_CAP) ? MAX_BOARD : BOARD_CAP;
    localparam int CW    = $clog2(LIMIT + 1);      // counts 0..LIMIT
    localparam int RW    = $clog2(LIMIT);          // row / column index
    localparam int DMW   = 2 * LIMIT - 1;          // diagonals
    localparam int SW    = $clog2(2 * LIMIT + 1);  // diagonal index sums
    localparam logic [LIMIT-1:0] ROW_ONE  = 1;
    localparam logic [DMW-1:0]   DIAG_ONE = 1;

    logic [CW-1:0]    n_reg, col_reg, row_reg;
    logic [LIMIT-1:0] row_mask_reg;
    logic [DMW-1:0]   rise_mask_reg, fall_mask_reg;
    logic [COL_W-1:0] out_col_reg;
    logic [ROW_W-1:0] out_row_reg;
    logic             out_found_reg, out_last_reg, out_valid_reg;

    logic [IN_W-1:0]  n_sat;
    logic [CW-1:0]    col_m1;
    logic [RW-1:0]    rd_addr, rd_data;
    logic [SW-1:0]    rise_idx, fall_idx, tg_rise_idx, tg_fall_idx;
    logic [LIMIT-1:0] row_sh;
    logic [DMW-1:0]   rise_sh, fall_sh;
    logic [CW-1:0]    tg_row;
    logic [LIMIT-1:0] row_mask_next;
    logic [DMW-1:0]   rise_mask_next, fall_mask_next;

    // Saturate board size to the supported limit
    assign n_sat  = (board_size > IN_W'(LIMIT)) ? IN_W'(LIMIT) : board_size;
    assign col_m1 = col_reg - CW'(1);

    // Row store: one entry per column
    assign rd_addr = cmd.dec_col ? col_m1[RW-1:0] : col_reg[RW-1:0];

    nqbs_ram #(
        .WIDTH (RW),
        .DEPTH (LIMIT)
    ) u_row_store (
        .clk     (clk),
        .wr_en   (cmd.place),
        .wr_addr (col_reg[RW-1:0]),
        .wr_data (row_reg[RW-1:0]),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Attack check for the trial cell
    assign rise_idx = SW'(row_reg) + SW'(col_reg);
    assign fall_idx = SW'(row_reg) + SW'(LIMIT - 1) - SW'(col_reg);
    assign row_sh   = row_mask_reg >> row_reg;
    assign rise_sh  = rise_mask_reg >> rise_idx;
    assign fall_sh  = fall_mask_reg >> fall_idx;

    // Queen toggle: trial row on place, stored row on pop
    assign tg_row      = cmd.pop ? CW'(rd_data) : row_reg;
    assign tg_rise_idx = SW'(tg_row) + SW'(col_reg);
    assign tg_fall_idx = SW'(tg_row) + SW'(LIMIT - 1) - SW'(col_reg);

    always_comb
    begin
        row_mask_next  = row_mask_reg;
        rise_mask_next = rise_mask_reg;
        fall_mask_next = fall_mask_reg;
        if (cmd.load)
        begin
            row_mask_next  = '0;
            rise_mask_next = '0;
            fall_mask_next = '0;
        end
        else if (cmd.place || cmd.pop)
        begin
            row_mask_next  = row_mask_reg ^ (ROW_ONE << tg_row);
            rise_mask_next = rise_mask_reg ^ (DIAG_ONE << tg_rise_idx);
            fall_mask_next = fall_mask_reg ^ (DIAG_ONE << tg_fall_idx);
        end
    end

    // Search state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg         <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            row_mask_reg  <= '0;
            rise_mask_reg <= '0;
            fall_mask_reg <= '0;
        end
        else
        begin
            row_mask_reg  <= row_mask_next;
            rise_mask_reg <= rise_mask_next;
            fall_mask_reg <= fall_mask_next;
            if (cmd.load)
            begin
                n_reg   <= CW'(n_sat);
                col_reg <= '0;
                row_reg <= '0;
            end
            else if (cmd.place)
            begin
                col_reg <= col_reg + CW'(1);
                row_reg <= '0;
            end
            else if (cmd.advance)
            begin
                row_reg <= row_reg + CW'(1);
            end
            else if (cmd.dec_col)
            begin
                col_reg <= col_m1;
            end
            else if (cmd.pop)
            begin
                row_reg <= CW'(rd_data) + CW'(1);
            end
            else if (cmd.out_start)
            begin
                col_reg <= '0;
            end
            else if (cmd.next_col)
            begin
                col_reg <= col_reg + CW'(1);
            end
        end
    end

    // Status toward the controller
    assign st.n_zero   = (n_reg == '0);
    assign st.col_done = (col_reg >= n_reg);
    assign st.row_done = (row_reg >= n_reg);
    assign st.col_zero = (col_reg == '0);
    assign st.safe     = !(row_sh[0] || rise_sh[0] || fall_sh[0]);
    assign st.last_col = (({1'b0, col_reg} + (CW + 1)'(1)) == {1'b0, n_reg});
    assign st.out_free = !out_valid_reg || out_ready;

    // Output register: valid is control, payload loads on emit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_row || cmd.emit_none)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_row)
        begin
            out_col_reg   <= COL_W'(col_reg);
            out_row_reg   <= ROW_W'(rd_data);
            out_found_reg <= 1'b1;
            out_last_reg  <= st.last_col;
        end
        else if (cmd.emit_none)
        begin
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            out_found_reg <= 1'b0;
            out_last_reg  <= 1'b1;
        end
    end

    assign out_col   = out_col_reg;
    assign out_row   = out_row_reg;
    assign out_found = out_found_reg;
    assign out_last  = out_last_reg;
    assign out_valid = out_valid_reg;

    // Checks
    `NQ_ASSERT_IMPL(a_emit_no_overwrite, clk, rst_n, cmd.emit_row || cmd.emit_none, !out_valid_reg || out_ready, "result loaded over a pending one")
    `NQ_ASSERT_IMPL(a_notfound_is_last, clk, rst_n, out_valid_reg && !out_found_reg, out_last_reg, "not-found result not marked last")
    `NQ_ASSERT_ALWAYS(a_col_in_board, clk, rst_n, col_reg <= n_reg, "column counter beyond board size")

endmodule

>>> rtl/core/nqbs_ctrl.sv
// Controller of the n-queens solver: search and readout sequencer.
// Depends on nqbs_pkg.
`timescale 1ns / 1ps

module nqbs_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  nqbs_pkg::status_t st,
    output nqbs_pkg::cmd_t    cmd
);

    import nqbs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_CHECK,
        S_POP,
        S_OUT_READ,
        S_OUT_EMIT,
        S_NONE
    } state_t;

    state_t state_reg, state_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                state_next = st.n_zero ? S_NONE : S_CHECK;
            end
            S_CHECK:
            begin
                priority if (st.col_done)
                begin
                    cmd.out_start = 1'b1;
                    state_next    = S_OUT_READ;
                end
                else if (st.row_done)
                begin
                    if (st.col_zero)
                    begin
                        state_next = S_NONE;
                    end
                    else
                    begin
                        cmd.dec_col = 1'b1;
                        state_next  = S_POP;
                    end
                end
                else if (st.safe)
                begin
                    cmd.place = 1'b1;
                end
                else
                begin
                    cmd.advance = 1'b1;
                end
            end
            S_POP:
            begin
                cmd.pop    = 1'b1;
                state_next = S_CHECK;
            end
            S_OUT_READ:
            begin
                state_next = S_OUT_EMIT;
            end
            S_OUT_EMIT:
            begin
                if (st.out_free)
                begin
                    cmd.emit_row = 1'b1;
                    cmd.next_col = 1'b1;
                    state_next   = st.last_col ? S_IDLE : S_OUT_READ;
                end
            end
            S_NONE:
            begin
                if (st.out_free)
                begin
                    cmd.emit_none = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);

endmodule

>>> rtl/core/n_queens_backtrack_solver_top.sv
// Every request on s_* carries a board size n (values above the supported limit of
// min(MAX_BOARD, 16) saturate to it) and returns the first placement of n non-attacking
// queens found by depth-first search, one transaction per column with tlast on the final
// column; n = 0, 2 or 3 returns a single transaction with tuser = 0 (not found). The
// search tries one cell per cycle in the controller's check state; each backtrack passes
// through the pop state for the row-store read, and each result is read out through the
// read and emit states. One request is worked at a time.
// Depends on nqbs_pkg, nqbs_ctrl, nqbs_datapath.
`timescale 1ns / 1ps

module n_queens_backtrack_solver_top #(
    parameter int MAX_BOARD = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [4:0] board_size, [7:5] zero
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [3:0] column_index, [7:4] queen_row
    output logic       m_tuser,   // [0] found
    output logic       m_tlast    // last_of_run
);

    import nqbs_pkg::*;

    cmd_t             cmd;
    status_t          st;
    logic [COL_W-1:0] out_col;
    logic [ROW_W-1:0] out_row;

    // Search and readout sequencer
    nqbs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .st        (st),
        .cmd       (cmd)
    );

    // Masks, counters, row store and output register
    nqbs_datapath #(
        .MAX_BOARD (MAX_BOARD)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .st         (st),
        .board_size (s_tdata[IN_W-1:0]),
        .out_col    (out_col),
        .out_row    (out_row),
        .out_found  (m_tuser),
        .out_last   (m_tlast),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready)
    );

    assign m_tdata = {out_row, out_col};

endmodule
